/* rtl/core/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types and codes of the per-CPU preemption tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int N_CPUS_DEF     = 16;
	localparam int DEPTH_BITS_DEF = 8;

	localparam int ACT_W  = 3;
	localparam int CPU_W  = 4;
	localparam int TICK_W = 64;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 5;

	localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ENABLE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TICK    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SLEEP   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_WAKE    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE        = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_DISABLED = 2'd2;
	localparam logic [STAT_W-1:0] ST_SCHED_FAIL   = 2'd3;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [CPU_W-1:0]  cpu_index;
		logic [TICK_W-1:0] sleep_ticks;
		logic [TICK_W-1:0] wake_time;
		logic              schedule_ok;
	} ppt_in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic              schedule_request;
		logic              is_preemptible;
		logic [TICK_W-1:0] tick_count;
		logic [TICK_W-1:0] switch_count;
	} ppt_out_t;

	typedef struct packed {
		logic in_ready;
		logic rd_en;
		logic rd_sel_cpu;
		logic wk_clr;
		logic wk_step;
		logic wake_chk;
		logic exec;
		logic load_out;
	} ppt_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic is_wake;
		logic wk_last;
		logic out_free;
	} ppt_sts_t;

endpackage

/* rtl/core/ppt_chan_if.sv */
// ----------------------------------------------------------------------------
// ppt_chan_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface ppt_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/per_cpu_preemption_tracker.sv */
// ----------------------------------------------------------------------------
// per_cpu_preemption_tracker
// Per-CPU preemption depth, tick, switch and sleep deadline tracker.
// ----------------------------------------------------------------------------
// Usage:
// items carries one action word (disable, enable, tick, sleep, wake, query)
// for one cpu; results returns exactly one word per action, in order.
// cfg_wr_en/cfg_wr_data set cpus_in_use (1..N_CPUS, other values are
// dropped); a valid write clears all per-cpu state. Write only while idle.
// Flow: an accepted action is decoded, swept (wake only), read, updated
// and its result loaded into the output register; the next action is
// taken only after that load. A wake sweeps the cpus in use through the
// single state memory port, one cpu a cycle, before the addressed cpu is read.
// Reset: cpus_in_use returns to 1 and all per-cpu state reads as zero
// immediately, through per-entry valid flags; no clearing pass.
// A stalled results channel holds its word; one further action is taken
// and processed meanwhile, and its result waits until the output frees.
// ----------------------------------------------------------------------------
module per_cpu_preemption_tracker #(
	parameter int N_CPUS     = ppt_pkg::N_CPUS_DEF,
	parameter int DEPTH_BITS = ppt_pkg::DEPTH_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [ppt_pkg::CFG_W-1:0] cfg_wr_data,
	ppt_chan_if.sink                  items,
	ppt_chan_if.source                results
);

	ppt_pkg::ppt_cmd_t cmd;
	ppt_pkg::ppt_sts_t sts;

	ppt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ppt_dp #(
		.N_CPUS     (N_CPUS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.items       (items),
		.results     (results),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

/* rtl/core/ppt_ctrl.sv */
// ----------------------------------------------------------------------------
// ppt_ctrl
// Sequencer of the preemption tracker: accept, wake sweep, update, deliver.
// ----------------------------------------------------------------------------
module ppt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  ppt_pkg::ppt_sts_t sts,
	output ppt_pkg::ppt_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_WAKE = 3'd2;
	localparam logic [2:0] S_WEND = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_EX   = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       chk_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.wk_clr   = 1'b1;
				if (sts.in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = sts.is_wake ? S_WAKE : S_RD;
			end
			S_WAKE: begin
				cmd.rd_en    = 1'b1;
				cmd.wk_step  = 1'b1;
				cmd.wake_chk = chk_q;
				if (sts.wk_last) begin
					state_d = S_WEND;
				end
			end
			S_WEND: begin
				cmd.wake_chk = chk_q;
				state_d      = S_RD;
			end
			S_RD: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_sel_cpu = 1'b1;
				state_d        = S_EX;
			end
			S_EX: begin
				cmd.exec = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_q   <= (state_q == S_WAKE);
		end
	end

endmodule

/* rtl/core/ppt_dp.sv */
// ----------------------------------------------------------------------------
// ppt_dp
// Datapath of the preemption tracker: per-CPU state memory, update, result.
// ----------------------------------------------------------------------------
module ppt_dp #(
	parameter int N_CPUS     = ppt_pkg::N_CPUS_DEF,
	parameter int DEPTH_BITS = ppt_pkg::DEPTH_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [ppt_pkg::CFG_W-1:0] cfg_wr_data,
	ppt_chan_if.sink                 items,
	ppt_chan_if.source               results,
	input  ppt_pkg::ppt_cmd_t        cmd,
	output ppt_pkg::ppt_sts_t        sts
);

	localparam int TW  = ppt_pkg::TICK_W;
	localparam int AW  = (N_CPUS > 1) ? $clog2(N_CPUS) : 1;
	localparam int IW  = ((AW > ppt_pkg::CFG_W) ? AW : ppt_pkg::CFG_W) + 1;
	localparam int RW  = DEPTH_BITS + 3 * TW;
	localparam int DL0 = 0;
	localparam int SW0 = TW;
	localparam int TK0 = 2 * TW;
	localparam int DP0 = 3 * TW;

	// item registers
	logic [ppt_pkg::ACT_W-1:0] act_q;
	logic [ppt_pkg::CPU_W-1:0] cpu_q;
	logic [TW-1:0]             slp_q;
	logic [TW-1:0]             now_q;
	logic                      sok_q;

	logic [ppt_pkg::CFG_W-1:0] cpus_q;
	logic [AW-1:0]             idx_q;
	logic [N_CPUS-1:0]         vld_q;
	logic [RW-1:0]             mem_q [N_CPUS];
	logic [RW-1:0]             rd_row_s1;
	logic [AW-1:0]             rd_addr_s1;
	logic                      rd_vld_s1;
	ppt_pkg::ppt_out_t         res_q;
	ppt_pkg::ppt_out_t         out_q;
	logic                      out_vld_q;

	logic                  accept;
	logic                  cfg_ok;
	logic                  cpu_ok;
	logic [AW-1:0]         cpu_addr;
	logic [AW-1:0]         rd_addr;
	logic [RW-1:0]         row;
	logic [DEPTH_BITS-1:0] dp;
	logic [TW-1:0]         tk;
	logic [TW-1:0]         sw;
	logic [TW-1:0]         dl;
	logic [DEPTH_BITS-1:0] n_dp;
	logic [TW-1:0]         n_tk;
	logic [TW-1:0]         n_sw;
	logic [TW-1:0]         n_dl;
	logic [ppt_pkg::STAT_W-1:0] stat;
	logic                  req;
	logic                  ex_wr;
	logic                  expired;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [RW-1:0]         wr_row;
	ppt_pkg::ppt_out_t     res_d;

	assign accept   = items.valid && items.ready;
	assign items.ready = cmd.in_ready;
	assign cfg_ok   = cfg_wr_en && (cfg_wr_data != '0)
		&& (IW'(cfg_wr_data) <= IW'(N_CPUS));
	assign cpu_ok   = (IW'(cpu_q) < IW'(cpus_q)) && (IW'(cpu_q) < IW'(N_CPUS));
	assign cpu_addr = AW'(cpu_q);
	assign rd_addr  = cmd.rd_sel_cpu ? cpu_addr : idx_q;

	assign sts.in_valid = items.valid;
	assign sts.is_wake  = (act_q == ppt_pkg::ACT_WAKE);
	assign sts.wk_last  = (IW'(idx_q) + IW'(1)) == IW'(cpus_q);
	assign sts.out_free = !out_vld_q || results.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= items.data.action;
			cpu_q <= items.data.cpu_index;
			slp_q <= items.data.sleep_ticks;
			now_q <= items.data.wake_time;
			sok_q <= items.data.schedule_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpus_q <= ppt_pkg::CFG_W'(1);
		end else if (cfg_ok) begin
			cpus_q <= cfg_wr_data;
		end
	end

	// wake sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.wk_clr) begin
			idx_q <= '0;
		end else if (cmd.wk_step) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// state memory
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_row_s1  <= mem_q[rd_addr];
			rd_addr_s1 <= rd_addr;
			rd_vld_s1  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cfg_ok) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// update of the addressed cpu
	always_comb begin
		row  = rd_vld_s1 ? rd_row_s1 : '0;
		dp   = row[DP0 +: DEPTH_BITS];
		tk   = row[TK0 +: TW];
		sw   = row[SW0 +: TW];
		dl   = row[DL0 +: TW];
		n_dp = dp;
		n_tk = tk;
		n_sw = sw;
		n_dl = dl;
		stat = ppt_pkg::ST_OK;
		req  = 1'b0;
		ex_wr = 1'b0;
		case (act_q)
			ppt_pkg::ACT_DISABLE: begin
				if (cpu_ok && (dp != '1)) begin
					n_dp  = dp + DEPTH_BITS'(1);
					ex_wr = 1'b1;
				end
			end
			ppt_pkg::ACT_ENABLE: begin
				if (!cpu_ok) begin
					stat = ppt_pkg::ST_RANGE;
				end else if (dp == '0) begin
					stat = ppt_pkg::ST_NOT_DISABLED;
				end else begin
					n_dp  = dp - DEPTH_BITS'(1);
					ex_wr = 1'b1;
				end
			end
			ppt_pkg::ACT_TICK: begin
				if (!cpu_ok) begin
					stat = ppt_pkg::ST_RANGE;
				end else begin
					n_tk  = tk + TW'(1);
					ex_wr = 1'b1;
					if ((dp == '0) && (dl == '0)) begin
						req = 1'b1;
						if (sok_q) begin
							n_sw = sw + TW'(1);
						end else begin
							stat = ppt_pkg::ST_SCHED_FAIL;
						end
					end
				end
			end
			ppt_pkg::ACT_SLEEP: begin
				if (!cpu_ok) begin
					stat = ppt_pkg::ST_RANGE;
				end else begin
					n_dl  = tk + slp_q;
					ex_wr = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign expired = (dl != '0) && (dl <= now_q);

	always_comb begin
		wr_en   = (cmd.exec && ex_wr) || (cmd.wake_chk && expired);
		wr_addr = cmd.wake_chk ? rd_addr_s1 : cpu_addr;
		if (cmd.wake_chk) begin
			wr_row = {dp, tk, sw, TW'(0)};
		end else begin
			wr_row = {n_dp, n_tk, n_sw, n_dl};
		end
	end

	always_comb begin
		res_d.status           = stat;
		res_d.schedule_request = req;
		res_d.is_preemptible   = cpu_ok && (n_dp == '0) && (n_dl == '0);
		res_d.tick_count       = cpu_ok ? n_tk : '0;
		res_d.switch_count     = cpu_ok ? n_sw : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign results.valid = out_vld_q;
	assign results.data  = out_q;

`ifndef NO_ASSERTIONS
	a_chk_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wake_chk |-> $past(cmd.rd_en))
		else $error("wake check without a preceding read");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (IW'(wr_addr) < IW'(cpus_q)))
		else $error("state write outside the cpus in use");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.wake_chk))
		else $error("update and wake check in the same cycle");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(cmd.load_out))
		else $error("result word appeared without a load");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !items.ready)
		else $error("second word accepted while busy");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for per_cpu_preemption_tracker. Action words go in
// through the items channel and are predicted by a behavioral copy of the
// per-cpu depth, tick, switch and deadline state. Every result word is
// compared field by field. The run covers directed corner actions, register
// writes with valid and dropped values, depth saturation and random action
// sequences, some with malformed words. Both channels are paced with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int TW  = ppt_pkg::TICK_W;
	localparam int CW  = ppt_pkg::CPU_W;
	localparam int FW  = ppt_pkg::CFG_W;
	localparam int ACW = ppt_pkg::ACT_W;
	localparam int DW  = ppt_pkg::DEPTH_BITS_DEF;
	localparam int NC  = ppt_pkg::N_CPUS_DEF;

	localparam logic [ACW-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACW-1:0] ACT_SPARE_7 = 3'd7;

	logic          clk;
	logic          arst_n;
	logic          cfg_wr_en;
	logic [FW-1:0] cfg_wr_data;

	ppt_chan_if #(.T(ppt_pkg::ppt_in_t))  item_ch ();
	ppt_chan_if #(.T(ppt_pkg::ppt_out_t)) result_ch ();

	per_cpu_preemption_tracker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.items      (item_ch),
		.results    (result_ch)
	);

	int            cpus_tracked;
	logic [DW-1:0] depth_m    [NC];
	logic [TW-1:0] tick_m     [NC];
	logic [TW-1:0] switch_m   [NC];
	logic [TW-1:0] deadline_m [NC];

	ppt_pkg::ppt_out_t owed_reports [$];
	ppt_pkg::ppt_out_t owed_head;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                words_sent;
	int                results_checked;
	int                mismatches;

	always #10 clk = ~clk;

	function automatic logic [TW-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic rand_bit();
		return $urandom_range(1) != 0;
	endfunction

	function automatic logic [CW-1:0] rand_cpu();
		return CW'($urandom_range(15));
	endfunction

	function automatic void clear_tracker();
		for (int i = 0; i < NC; i++) begin
			depth_m[i]    = '0;
			tick_m[i]     = '0;
			switch_m[i]   = '0;
			deadline_m[i] = '0;
		end
	endfunction

	function automatic logic [CW-1:0] pick_cpu();
		if ($urandom_range(9) == 0)
			return rand_cpu();
		return CW'($urandom_range(cpus_tracked - 1));
	endfunction

	function automatic ppt_pkg::ppt_out_t track_action(ppt_pkg::ppt_in_t w);
		ppt_pkg::ppt_out_t r;
		int                c;
		logic              hit;
		c   = int'(w.cpu_index);
		hit = (c < cpus_tracked);
		r   = '0;
		r.status = ppt_pkg::ST_OK;
		case (w.action)
			ppt_pkg::ACT_DISABLE: begin
				if (hit && depth_m[c] != '1)
					depth_m[c] = depth_m[c] + DW'(1);
			end
			ppt_pkg::ACT_ENABLE: begin
				if (!hit)
					r.status = ppt_pkg::ST_RANGE;
				else if (depth_m[c] == '0)
					r.status = ppt_pkg::ST_NOT_DISABLED;
				else
					depth_m[c] = depth_m[c] - DW'(1);
			end
			ppt_pkg::ACT_TICK: begin
				if (!hit) begin
					r.status = ppt_pkg::ST_RANGE;
				end else begin
					tick_m[c] = tick_m[c] + TW'(1);
					if (depth_m[c] == '0 && deadline_m[c] == '0) begin
						r.schedule_request = 1'b1;
						if (w.schedule_ok)
							switch_m[c] = switch_m[c] + TW'(1);
						else
							r.status = ppt_pkg::ST_SCHED_FAIL;
					end
				end
			end
			ppt_pkg::ACT_SLEEP: begin
				if (!hit)
					r.status = ppt_pkg::ST_RANGE;
				else
					deadline_m[c] = tick_m[c] + w.sleep_ticks;
			end
			ppt_pkg::ACT_WAKE: begin
				for (int i = 0; i < cpus_tracked; i++)
					if (deadline_m[i] != '0 && deadline_m[i] <= w.wake_time)
						deadline_m[i] = '0;
			end
			default: ;
		endcase
		r.is_preemptible = hit && depth_m[c] == '0 && deadline_m[c] == '0;
		r.tick_count     = hit ? tick_m[c] : '0;
		r.switch_count   = hit ? switch_m[c] : '0;
		return r;
	endfunction

	function automatic void diff_field(string name, logic [TW-1:0] want,
			logic [TW-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s, result %0d: expected %h, got %h",
					name, results_checked, want, got);
		end
	endfunction

	// result side: random stalls, compare each accepted word
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			results_checked++;
			if (owed_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with nothing pending: %p", result_ch.data);
			end else begin
				owed_head = owed_reports.pop_front();
				diff_field("status", TW'(owed_head.status),
					TW'(result_ch.data.status));
				diff_field("schedule_request", TW'(owed_head.schedule_request),
					TW'(result_ch.data.schedule_request));
				diff_field("is_preemptible", TW'(owed_head.is_preemptible),
					TW'(result_ch.data.is_preemptible));
				diff_field("tick_count", owed_head.tick_count, result_ch.data.tick_count);
				diff_field("switch_count", owed_head.switch_count,
					result_ch.data.switch_count);
			end
		end
		result_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_word(input logic [ACW-1:0] act, input logic [CW-1:0] cpu,
			input logic [TW-1:0] slp, input logic [TW-1:0] now_t, input logic sok);
		ppt_pkg::ppt_in_t w;
		w.action      = act;
		w.cpu_index   = cpu;
		w.sleep_ticks = slp;
		w.wake_time   = now_t;
		w.schedule_ok = sok;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do @(posedge clk); while (!item_ch.ready);
		owed_reports.push_back(track_action(w));
		words_sent++;
	endtask

	task automatic wait_all_reported();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (owed_reports.size() != 0);
	endtask

	task automatic write_cpus(input logic [FW-1:0] value);
		wait_all_reported();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (value != '0 && int'(value) <= NC) begin
			cpus_tracked = int'(value);
			clear_tracker();
		end
	endtask

	task automatic test_reset_state();
		send_word(ppt_pkg::ACT_QUERY, 4'd0, '0, '0, 1'b0);
		send_word(ppt_pkg::ACT_ENABLE, 4'd0, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd0, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd0, '0, '0, 1'b0);
		send_word(ppt_pkg::ACT_DISABLE, 4'd3, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_ENABLE, 4'd15, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd15, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_SLEEP, 4'd15, 64'd5, '0, 1'b1);
		send_word(ppt_pkg::ACT_QUERY, 4'd15, '0, '0, 1'b0);
		send_word(ACT_SPARE_6, 4'd0, '1, '1, 1'b1);
		send_word(ACT_SPARE_7, 4'd15, '1, '1, 1'b1);
		send_word(ppt_pkg::ACT_WAKE, 4'd9, '0, '1, 1'b0);
	endtask

	task automatic test_corner_actions();
		write_cpus(5'd16);
		send_word(ppt_pkg::ACT_DISABLE, 4'd15, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd15, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_ENABLE, 4'd15, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd15, '0, '0, 1'b1);
		// zero-length sleep and a deadline that wraps to zero both leave it awake
		send_word(ppt_pkg::ACT_SLEEP, 4'd2, 64'd0, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd2, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_SLEEP, 4'd2, '1, '0, 1'b1);
		send_word(ppt_pkg::ACT_SLEEP, 4'd2, 64'd5, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd2, '0, '0, 1'b0);
		send_word(ppt_pkg::ACT_WAKE, 4'd2, '0, 64'd5, 1'b0);
		send_word(ppt_pkg::ACT_WAKE, 4'd2, '0, 64'd6, 1'b0);
		send_word(ppt_pkg::ACT_SLEEP, 4'd4, '1, '0, 1'b1);
		send_word(ppt_pkg::ACT_WAKE, 4'd4, '0, '1, 1'b1);
		send_word(ppt_pkg::ACT_QUERY, 4'd4, '0, '0, 1'b1);
	endtask

	task automatic test_register_writes();
		write_cpus(5'd9);
		send_word(ppt_pkg::ACT_DISABLE, 4'd8, '0, '0, 1'b1);
		send_word(ppt_pkg::ACT_TICK, 4'd8, '0, '0, 1'b1);
		write_cpus(5'd0);
		send_word(ppt_pkg::ACT_QUERY, 4'd8, '0, '0, 1'b0);
		write_cpus(5'd17);
		send_word(ppt_pkg::ACT_QUERY, 4'd8, '0, '0, 1'b0);
		write_cpus(5'd31);
		send_word(ppt_pkg::ACT_TICK, 4'd12, '0, '0, 1'b1);
		write_cpus(5'd16);
		send_word(ppt_pkg::ACT_QUERY, 4'd8, '0, '0, 1'b0);
		send_word(ppt_pkg::ACT_TICK, 4'd15, '0, '0, 1'b1);
		write_cpus(5'd1);
		send_word(ppt_pkg::ACT_QUERY, 4'd1, '0, '0, 1'b0);
		send_word(ppt_pkg::ACT_TICK, 4'd0, '0, '0, 1'b1);
	endtask

	task automatic test_depth_saturation();
		logic [CW-1:0] c;
		write_cpus(5'd16);
		c = rand_cpu();
		repeat (258) send_word(ppt_pkg::ACT_DISABLE, c, rand64(), rand64(), rand_bit());
		send_word(ppt_pkg::ACT_TICK, c, rand64(), rand64(), rand_bit());
		repeat (256) send_word(ppt_pkg::ACT_ENABLE, c, rand64(), rand64(), rand_bit());
		send_word(ppt_pkg::ACT_TICK, c, rand64(), rand64(), 1'b1);
	endtask

	task automatic test_random_traffic(input int budget);
		int            stop_at;
		int            kind;
		int            k;
		logic [CW-1:0] c;
		logic [TW-1:0] slp;
		logic [TW-1:0] dl;
		logic [TW-1:0] now_t;
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			kind = $urandom_range(99);
			c    = pick_cpu();
			if (kind < 12) begin
				send_word(ACW'($urandom_range(7)), rand_cpu(), rand64(), rand64(),
					rand_bit());
			end else if (kind < 40) begin
				// nested critical section, sometimes one enable too many
				k = $urandom_range(1, 4);
				repeat (k) send_word(ppt_pkg::ACT_DISABLE, c, rand64(), rand64(), rand_bit());
				repeat ($urandom_range(0, 3))
					send_word(ppt_pkg::ACT_TICK, c, rand64(), rand64(), rand_bit());
				repeat (k + (($urandom_range(3) == 0) ? 1 : 0))
					send_word(ppt_pkg::ACT_ENABLE, c, rand64(), rand64(), rand_bit());
				send_word(ppt_pkg::ACT_TICK, c, rand64(), rand64(), rand_bit());
			end else if (kind < 75) begin
				repeat ($urandom_range(0, 2))
					send_word(ppt_pkg::ACT_TICK, c, rand64(), rand64(), rand_bit());
				case ($urandom_range(9))
					0: slp = rand64();
					1: slp = 64'd0 - tick_m[c];
					default: slp = TW'($urandom_range(0, 12));
				endcase
				send_word(ppt_pkg::ACT_SLEEP, c, slp, rand64(), rand_bit());
				repeat ($urandom_range(0, 2))
					send_word(ppt_pkg::ACT_TICK, c, rand64(), rand64(), rand_bit());
				dl = deadline_m[c];
				case ($urandom_range(4))
					0: now_t = dl - 64'd1;
					1: now_t = dl;
					2: now_t = dl + TW'($urandom_range(1, 5));
					3: now_t = rand64();
					default: now_t = tick_m[c] + TW'($urandom_range(0, 15));
				endcase
				send_word(ppt_pkg::ACT_WAKE, rand_cpu(), rand64(), now_t, rand_bit());
				send_word(ppt_pkg::ACT_QUERY, c, rand64(), rand64(), rand_bit());
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 5))
					send_word(ppt_pkg::ACT_TICK, c, rand64(), rand64(), rand_bit());
			end else if (kind < 98) begin
				send_word(ppt_pkg::ACT_QUERY, c, rand64(), rand64(), rand_bit());
			end else begin
				wait_all_reported();
			end
		end
		wait_all_reported();
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		words_sent      = 0;
		results_checked = 0;
		mismatches      = 0;
		cpus_tracked    = 1;
		clear_tracker();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_corner_actions();
		test_register_writes();
		test_depth_saturation();

		send_idle_pct = 0;  recv_stall_pct = 0;
		write_cpus(5'd16);
		test_random_traffic(300);
		send_idle_pct = 47; recv_stall_pct = 0;
		write_cpus(5'd1);
		test_random_traffic(300);
		send_idle_pct = 0;  recv_stall_pct = 47;
		write_cpus(FW'($urandom_range(2, 15)));
		test_random_traffic(300);
		send_idle_pct = 31; recv_stall_pct = 31;
		write_cpus(5'd16);
		test_random_traffic(300);

		wait_all_reported();
		repeat (40) @(posedge clk);
		$display("covered %0d action words and %0d result words, cpus_in_use 1 to 16",
			words_sent, results_checked);
		$display("with dropped register values, depth saturation, sender gaps and stalls");
		if (mismatches == 0 && owed_reports.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
